@@ rtl/core/irpwfd_pkg.sv @@
// ----------------------------------------------------------------------------
// irpwfd_pkg
// shared types and constants of the ir pulse width frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

package irpwfd_pkg;

  // configuration register file
  localparam int unsigned CFG_BITS     = 18;
  localparam int unsigned CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ONE_WIDTH    = 3'd0,
    CFG_ZERO_WIDTH   = 3'd1,
    CFG_START_WIDTH  = 3'd2,
    CFG_STOP_WIDTH   = 3'd3,
    CFG_BELOW_MARGIN = 3'd4,
    CFG_ABOVE_MARGIN = 3'd5
  } cfg_idx_e;

  localparam logic [CFG_BITS-1:0] ONE_WIDTH_RST    = 18'd400;
  localparam logic [CFG_BITS-1:0] ZERO_WIDTH_RST   = 18'd200;
  localparam logic [CFG_BITS-1:0] START_WIDTH_RST  = 18'd600;
  localparam logic [CFG_BITS-1:0] STOP_WIDTH_RST   = 18'd800;
  localparam logic [CFG_BITS-1:0] BELOW_MARGIN_RST = 18'd50;
  localparam logic [CFG_BITS-1:0] ABOVE_MARGIN_RST = 18'd50;

  typedef struct packed {
    logic [CFG_BITS-1:0] one_width;
    logic [CFG_BITS-1:0] zero_width;
    logic [CFG_BITS-1:0] start_width;
    logic [CFG_BITS-1:0] stop_width;
    logic [CFG_BITS-1:0] below_margin;
    logic [CFG_BITS-1:0] above_margin;
  } cfg_t;

  // pulse classes, in priority order of the window checks
  typedef enum logic [2:0] {
    SYM_ONE   = 3'd0,
    SYM_ZERO  = 3'd1,
    SYM_START = 3'd2,
    SYM_STOP  = 3'd3,
    SYM_BAD   = 3'd4
  } sym_e;

  // frame layout
  localparam int unsigned   DATA_BITS     = 8;
  localparam int unsigned   POS_BITS      = 4;
  localparam logic [3:0]    FRAME_SYMBOLS = 4'd9;
  localparam logic [3:0]    POS_MAX       = 4'd15;

  // parameter defaults
  localparam int unsigned TICK_US_DEFAULT    = 4;
  localparam int unsigned COUNT_BITS_DEFAULT = 16;

endpackage

`default_nettype wire

@@ rtl/core/irpwfd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// irpwfd_cfg_regs
// window centre and margin registers, written over the config channel
// ----------------------------------------------------------------------------
`default_nettype none

module irpwfd_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [irpwfd_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [irpwfd_pkg::CFG_BITS-1:0]     cfg_data_i,
  output      irpwfd_pkg::cfg_t                    cfg_o
);

  irpwfd_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (irpwfd_pkg::cfg_idx_e'(cfg_index_i))
        irpwfd_pkg::CFG_ONE_WIDTH:    cfg_d.one_width    = cfg_data_i;
        irpwfd_pkg::CFG_ZERO_WIDTH:   cfg_d.zero_width   = cfg_data_i;
        irpwfd_pkg::CFG_START_WIDTH:  cfg_d.start_width  = cfg_data_i;
        irpwfd_pkg::CFG_STOP_WIDTH:   cfg_d.stop_width   = cfg_data_i;
        irpwfd_pkg::CFG_BELOW_MARGIN: cfg_d.below_margin = cfg_data_i;
        irpwfd_pkg::CFG_ABOVE_MARGIN: cfg_d.above_margin = cfg_data_i;
        default:                      cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_width    <= irpwfd_pkg::ONE_WIDTH_RST;
      cfg_q.zero_width   <= irpwfd_pkg::ZERO_WIDTH_RST;
      cfg_q.start_width  <= irpwfd_pkg::START_WIDTH_RST;
      cfg_q.stop_width   <= irpwfd_pkg::STOP_WIDTH_RST;
      cfg_q.below_margin <= irpwfd_pkg::BELOW_MARGIN_RST;
      cfg_q.above_margin <= irpwfd_pkg::ABOVE_MARGIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/irpwfd_pulse_meter.sv @@
// ----------------------------------------------------------------------------
// irpwfd_pulse_meter
// counts low samples and keeps the running pulse width in microseconds
// ----------------------------------------------------------------------------
`default_nettype none

module irpwfd_pulse_meter #(
  parameter int unsigned TICK_MICROSECONDS = irpwfd_pkg::TICK_US_DEFAULT,
  parameter int unsigned COUNT_BITS        = irpwfd_pkg::COUNT_BITS_DEFAULT,
  parameter int unsigned WIDTH_BITS        = COUNT_BITS + $clog2(TICK_MICROSECONDS + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic                  level_i,
  output      logic                  rise_o,
  output      logic [WIDTH_BITS-1:0] width_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  localparam logic [WIDTH_BITS-1:0] TickUs   = WIDTH_BITS'(TICK_MICROSECONDS);

  logic                  prev_level_q;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [WIDTH_BITS-1:0] width_q, width_d;

  // width tracks count times tick period by repeated addition
  always_comb begin
    count_d = count_q;
    width_d = width_q;
    if (!level_i) begin
      if (prev_level_q) begin
        count_d = COUNT_BITS'(1);
        width_d = TickUs;
      end else if (count_q != CountMax) begin
        count_d = count_q + COUNT_BITS'(1);
        width_d = width_q + TickUs;
      end
    end
  end

  assign rise_o  = step_i && level_i && !prev_level_q;
  assign width_o = width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b1;
      count_q      <= '0;
      width_q      <= '0;
    end else if (step_i) begin
      prev_level_q <= level_i;
      count_q      <= count_d;
      width_q      <= width_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/irpwfd_window.sv @@
// ----------------------------------------------------------------------------
// irpwfd_window
// strict window checks of a pulse width, one then zero then start then stop
// ----------------------------------------------------------------------------
`default_nettype none

module irpwfd_window #(
  parameter int unsigned WIDTH_BITS = 19
) (
  input  wire logic [WIDTH_BITS-1:0] width_i,
  input  wire irpwfd_pkg::cfg_t      cfg_i,
  output      irpwfd_pkg::sym_e      sym_o
);

  localparam int unsigned CB = irpwfd_pkg::CFG_BITS;
  localparam int unsigned SW = ((WIDTH_BITS > CB) ? WIDTH_BITS : CB) + 1;

  logic [SW-1:0] width_ext;
  logic [SW-1:0] low_sum;
  logic          in_one, in_zero, in_start, in_stop;

  function automatic logic inside_win(input logic [SW-1:0] w,
                                      input logic [SW-1:0] lo,
                                      input logic [CB-1:0] centre,
                                      input logic [CB-1:0] above);
    logic [SW-1:0] centre_ext;
    logic [SW-1:0] high_sum;
    centre_ext = SW'(centre);
    high_sum   = centre_ext + SW'(above);
    return (lo > centre_ext) && (w < high_sum);
  endfunction

  assign width_ext = SW'(width_i);
  assign low_sum   = width_ext + SW'(cfg_i.below_margin);

  assign in_one   = inside_win(width_ext, low_sum, cfg_i.one_width,   cfg_i.above_margin);
  assign in_zero  = inside_win(width_ext, low_sum, cfg_i.zero_width,  cfg_i.above_margin);
  assign in_start = inside_win(width_ext, low_sum, cfg_i.start_width, cfg_i.above_margin);
  assign in_stop  = inside_win(width_ext, low_sum, cfg_i.stop_width,  cfg_i.above_margin);

  always_comb begin
    priority if (in_one)   sym_o = irpwfd_pkg::SYM_ONE;
    else if     (in_zero)  sym_o = irpwfd_pkg::SYM_ZERO;
    else if     (in_start) sym_o = irpwfd_pkg::SYM_START;
    else if     (in_stop)  sym_o = irpwfd_pkg::SYM_STOP;
    else                   sym_o = irpwfd_pkg::SYM_BAD;
  end

endmodule

`default_nettype wire

@@ rtl/core/irpwfd_frame.sv @@
// ----------------------------------------------------------------------------
// irpwfd_frame
// frame bit collection, parity and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module irpwfd_frame (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             rise_i,
  input  wire irpwfd_pkg::sym_e                 sym_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  output      logic [irpwfd_pkg::DATA_BITS-1:0] frame_byte_o,
  output      logic                             length_error_o,
  output      logic                             parity_error_o,
  output      logic                             bad_pulse_o
);

  localparam int unsigned DB = irpwfd_pkg::DATA_BITS;
  localparam int unsigned PB = irpwfd_pkg::POS_BITS;

  logic [DB-1:0] bits_q, bits_d;
  logic [PB-1:0] pos_q, pos_d;
  logic          parity_q, parity_d;
  logic [PB-1:0] pos_next;
  logic          emit;

  logic          out_vld_q;
  logic [DB-1:0] byte_q;
  logic          len_err_q, par_err_q, bad_q;

  assign pos_next = (pos_q == irpwfd_pkg::POS_MAX) ? pos_q : pos_q + PB'(1);

  always_comb begin
    bits_d   = bits_q;
    pos_d    = pos_q;
    parity_d = parity_q;
    emit     = 1'b0;
    if (rise_i) begin
      unique case (sym_i)
        irpwfd_pkg::SYM_ONE: begin
          if (!pos_q[PB-1]) begin
            bits_d = bits_q | (DB'(1) << pos_q[PB-2:0]);
          end
          parity_d = ~parity_q;
          pos_d    = pos_next;
        end
        irpwfd_pkg::SYM_ZERO: begin
          pos_d = pos_next;
        end
        irpwfd_pkg::SYM_START: begin
          bits_d   = '0;
          pos_d    = '0;
          parity_d = 1'b0;
        end
        irpwfd_pkg::SYM_STOP,
        irpwfd_pkg::SYM_BAD: begin
          emit = 1'b1;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q    <= '0;
      pos_q     <= '0;
      parity_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      bits_q   <= bits_d;
      pos_q    <= pos_d;
      parity_q <= parity_d;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payload comes from the frame as it stands before this pulse
  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q    <= bits_q;
      len_err_q <= (pos_q != irpwfd_pkg::FRAME_SYMBOLS);
      par_err_q <= parity_q;
      bad_q     <= (sym_i == irpwfd_pkg::SYM_BAD);
    end
  end

  assign out_valid_o    = out_vld_q;
  assign frame_byte_o   = byte_q;
  assign length_error_o = len_err_q;
  assign parity_error_o = par_err_q;
  assign bad_pulse_o    = bad_q;

endmodule

`default_nettype wire

@@ rtl/core/ir_pulse_width_frame_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_width_frame_decoder_unit
// decodes pulse-width coded ir frames from one line sample per beat
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                 payload
// -------   ---  ------------------------  --------------------------------------
// in        in   in_valid_i / in_ready_o   line_level_i
// out       out  out_valid_o / out_ready_i frame_byte_o, length_error_o,
//                                          parity_error_o, bad_pulse_o
// cfg       in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one line sample per clock; the compare and update logic works on the sample
// held in the input register and, once that sample moves on, writes the result
// register, which lies behind the input register; the rate is one beat per
// cycle, held back only while a waiting result blocks the result register
// reset restores the default windows and an idle-high line, empty frame
// cfg_ready_o is always high; writes take effect on the next cycle
//
`default_nettype none

module ir_pulse_width_frame_decoder_unit #(
  parameter int unsigned TICK_MICROSECONDS = irpwfd_pkg::TICK_US_DEFAULT,
  parameter int unsigned COUNT_BITS        = irpwfd_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // sample channel
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic                                line_level_i,
  // result channel
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic [irpwfd_pkg::DATA_BITS-1:0]    frame_byte_o,
  output      logic                                length_error_o,
  output      logic                                parity_error_o,
  output      logic                                bad_pulse_o,
  // configuration channel
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [irpwfd_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [irpwfd_pkg::CFG_BITS-1:0]     cfg_data_i
);

  // enough bits for the saturated count times the tick period
  localparam int unsigned WidthBits = COUNT_BITS + $clog2(TICK_MICROSECONDS + 1);

  irpwfd_pkg::cfg_t      cfg;
  irpwfd_pkg::sym_e      sym;
  logic [WidthBits-1:0]  width;
  logic                  rise;

  // input register
  logic                  in_vld_q;
  logic                  level_q;
  logic                  step;

  // a sample moves on whenever the result register is free or draining
  assign step       = in_vld_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      level_q <= line_level_i;
    end
  end

  irpwfd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // low-sample counter and running width
  irpwfd_pulse_meter #(
    .TICK_MICROSECONDS (TICK_MICROSECONDS),
    .COUNT_BITS        (COUNT_BITS),
    .WIDTH_BITS        (WidthBits)
  ) u_pulse_meter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .level_i (level_q),
    .rise_o  (rise),
    .width_o (width)
  );

  // classify the finished pulse against the four windows
  irpwfd_window #(
    .WIDTH_BITS (WidthBits)
  ) u_window (
    .width_i (width),
    .cfg_i   (cfg),
    .sym_o   (sym)
  );

  // frame state and the result register
  irpwfd_frame u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rise_i         (rise),
    .sym_i          (sym),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_byte_o   (frame_byte_o),
    .length_error_o (length_error_o),
    .parity_error_o (parity_error_o),
    .bad_pulse_o    (bad_pulse_o)
  );

endmodule

`default_nettype wire
